/* hdl/cave_automaton_row_step_defines.svh */
// ---------------------------------------------------------------------------
// Cave automaton row step: assertion macros
// Shared assertion wrappers. Synthesis builds see empty bodies.
// ---------------------------------------------------------------------------
`ifndef CAVE_AUTOMATON_ROW_STEP_DEFINES_SVH
`define CAVE_AUTOMATON_ROW_STEP_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked assertion, switched off while reset is held.
`define CAVE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Clocked assertion that also holds through reset.
`define CAVE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define CAVE_ASSERT(lbl, prop, msg)
`define CAVE_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* hdl/cave_pkg.sv */
// ---------------------------------------------------------------------------
// Cave automaton package
// Widths, register indexes, reset values and the result entry type.
// ---------------------------------------------------------------------------
`default_nettype none

package cave_pkg;

  // Row geometry: lanes in use and the fixed width of a row word.
  localparam int ROW_CELLS = 64;
  localparam int CELL_W    = 64;

  // Register widths.
  localparam int LIMIT_W   = 4;
  localparam int WIDTH_W   = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 7;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DEATH_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIRTH_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH   = 2'd2;

  // Register reset values.
  localparam logic [LIMIT_W-1:0] DEATH_RST = 4'd3;
  localparam logic [LIMIT_W-1:0] BIRTH_RST = 4'd4;
  localparam logic [WIDTH_W-1:0] WIDTH_RST = 7'd64;

  // Result queue sizing.
  localparam int QUEUE_DEPTH = 4;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int PUSH_W      = 2;

  // One result entry.
  typedef struct packed {
    logic [CELL_W-1:0] cells;
    logic              done;
  } cave_res_t;

  // Push request towards the result queue.
  typedef struct packed {
    logic [PUSH_W-1:0] n;
    cave_res_t         e0;
    cave_res_t         e1;
  } cave_push_t;

endpackage

`default_nettype wire

/* hdl/cave_lane.sv */
// ---------------------------------------------------------------------------
// Cave automaton cell lane
// Counts the eight neighbours of one cell and applies the survival rule.
// ---------------------------------------------------------------------------
`default_nettype none

module cave_lane (
  input  wire logic [2:0]                     above,
  input  wire logic [2:0]                     mid,
  input  wire logic [2:0]                     below,
  input  wire logic [cave_pkg::LIMIT_W-1:0]   death_limit,
  input  wire logic [cave_pkg::LIMIT_W-1:0]   birth_limit,
  output logic                                cell_next
);

  logic [7:0] nbrs;
  logic [3:0] count;

  // Neighbour count, the centre cell excluded.
  assign nbrs  = {above, mid[2], mid[0], below};
  assign count = 4'($countones(nbrs));

  // A live cell survives unless starved; a dead cell needs a crowd.
  always_comb begin
    if (mid[1]) begin
      cell_next = (count >= death_limit);
    end else begin
      cell_next = (count > birth_limit);
    end
  end

endmodule

`default_nettype wire

/* hdl/cave_row_gen.sv */
// ---------------------------------------------------------------------------
// Cave automaton row generator
// Runs one lane per cell across a row and merges the lanes under the width.
// ---------------------------------------------------------------------------
`default_nettype none

module cave_row_gen (
  input  wire logic [cave_pkg::CELL_W-1:0]  above,
  input  wire logic [cave_pkg::CELL_W-1:0]  mid,
  input  wire logic [cave_pkg::CELL_W-1:0]  below,
  input  wire logic [cave_pkg::LIMIT_W-1:0] death_limit,
  input  wire logic [cave_pkg::LIMIT_W-1:0] birth_limit,
  input  wire logic [cave_pkg::WIDTH_W-1:0] row_width,
  output logic      [cave_pkg::CELL_W-1:0]  next_row
);

  logic [cave_pkg::WIDTH_W-1:0]   w_eff;
  logic [cave_pkg::CELL_W-1:0]    in_map;
  logic [cave_pkg::CELL_W+1:0]    ext_above;
  logic [cave_pkg::CELL_W+1:0]    ext_mid;
  logic [cave_pkg::CELL_W+1:0]    ext_below;
  logic [cave_pkg::CELL_W-1:0]    lane_out;
  logic [cave_pkg::ROW_CELLS-1:0] lane_bits;

  // Width saturates at the number of lanes.
  assign w_eff = (row_width > cave_pkg::WIDTH_W'(cave_pkg::ROW_CELLS)) ?
                 cave_pkg::WIDTH_W'(cave_pkg::ROW_CELLS) : row_width;

  // Columns inside the map.
  always_comb begin
    for (int c = 0; c < cave_pkg::CELL_W; c++) begin
      in_map[c] = (cave_pkg::WIDTH_W'(c) < w_eff);
    end
  end

  // Outside columns read as alive, with one live column padded on each side.
  assign ext_above = {1'b1, above | ~in_map, 1'b1};
  assign ext_mid   = {1'b1, mid   | ~in_map, 1'b1};
  assign ext_below = {1'b1, below | ~in_map, 1'b1};

  // One lane per cell; lanes beyond the row count stay dead.
  always_comb begin
    lane_out = '0;
    lane_out[cave_pkg::ROW_CELLS-1:0] = lane_bits;
  end

  for (genvar c = 0; c < cave_pkg::ROW_CELLS; c++) begin : g_lane
    cave_lane u_lane (
      .above       (ext_above[c+2:c]),
      .mid         (ext_mid[c+2:c]),
      .below       (ext_below[c+2:c]),
      .death_limit (death_limit),
      .birth_limit (birth_limit),
      .cell_next   (lane_bits[c])
    );
  end

  // Merge: cells outside the map are cleared.
  assign next_row = lane_out & in_map;

endmodule

`default_nettype wire

/* hdl/cave_out_queue.sv */
// ---------------------------------------------------------------------------
// Cave automaton result queue
// Shift queue that takes up to two results a cycle and presents the oldest.
// ---------------------------------------------------------------------------
`default_nettype none

`include "cave_automaton_row_step_defines.svh"

module cave_out_queue (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire cave_pkg::cave_push_t       push,
  output logic                            room,
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [cave_pkg::CELL_W-1:0]     out_tdata,   // [63:0] next_row_cells
  output logic                            out_tlast    // frame_done
);

  cave_pkg::cave_res_t             q_r   [cave_pkg::QUEUE_DEPTH];
  cave_pkg::cave_res_t             q_nxt [cave_pkg::QUEUE_DEPTH];
  logic [cave_pkg::QCNT_W-1:0]     count_r;
  logic [cave_pkg::QCNT_W-1:0]     count_nxt;
  logic [cave_pkg::QCNT_W-1:0]     base;
  logic                            pop;

  // Head of the queue drives the result channel.
  assign out_tvalid = (count_r != '0);
  assign out_tdata  = q_r[0].cells;
  assign out_tlast  = q_r[0].done;
  assign pop        = out_tvalid && out_tready;

  // Room for a two-result transaction.
  assign room = (count_r <= cave_pkg::QCNT_W'(cave_pkg::QUEUE_DEPTH - 2));

  // Next contents: shift on a pop, then append behind what remains.
  always_comb begin
    base = count_r - cave_pkg::QCNT_W'(pop);
    for (int i = 0; i < cave_pkg::QUEUE_DEPTH; i++) begin
      if (pop && (i < cave_pkg::QUEUE_DEPTH - 1)) begin
        q_nxt[i] = q_r[i+1];
      end else begin
        q_nxt[i] = q_r[i];
      end
      if ((push.n != '0) && (cave_pkg::QCNT_W'(i) == base)) begin
        q_nxt[i] = push.e0;
      end
      if ((push.n == cave_pkg::PUSH_W'(2)) &&
          (cave_pkg::QCNT_W'(i) == base + cave_pkg::QCNT_W'(1))) begin
        q_nxt[i] = push.e1;
      end
    end
    count_nxt = base + cave_pkg::QCNT_W'(push.n);
  end

  // Entry storage, no reset needed.
  always_ff @(posedge clk) begin
    for (int i = 0; i < cave_pkg::QUEUE_DEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  // Fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Checks on the fill level.
  `CAVE_ASSERT(a_count_bound, count_r <= cave_pkg::QCNT_W'(cave_pkg::QUEUE_DEPTH), "queue over depth")
  `CAVE_ASSERT(a_push_fits, (push.n != '0) |-> room, "push without room")
  `CAVE_ASSERT(a_pop_only, (pop && push.n == '0) |=> count_r == $past(count_r) - cave_pkg::QCNT_W'(1), "pop did not drain")

endmodule

`default_nettype wire

/* hdl/cave_automaton_row_step.sv */
// ---------------------------------------------------------------------------
// Cave automaton row step
// One smoothing generation of a cave map, streamed one row per transaction.
// ---------------------------------------------------------------------------
// Channel   Dir   Handshake              Payload
// in_       in    in_tvalid/in_tready    tdata row_cells, tlast final_row
// out_      out   out_tvalid/out_tready  tdata next_row_cells, tlast frame_done
// cfg_      in    cfg_wr_en              cfg_index, cfg_wdata
//
// A row is accepted every cycle while the four-entry result queue has room
// for two results; each result is computed in the accepting cycle by 64
// parallel lanes and is registered into the queue, offered once older results have left.
// The first row of a map returns nothing and its final row returns two
// results, so a map returns as many results as it has rows and one row per
// cycle is sustained when the output never stalls.
// Reset (synchronous, rst_n low) empties the queue, restores the registers
// and marks the row above as outside the map. A stalled output holds its
// head result while inputs keep being taken until the queue has no room for two results.
// ---------------------------------------------------------------------------
`default_nettype none

`include "cave_automaton_row_step_defines.svh"

module cave_automaton_row_step (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [cave_pkg::CELL_W-1:0]     in_tdata,    // [63:0] row_cells
  input  wire logic                            in_tlast,    // final_row
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic      [cave_pkg::CELL_W-1:0]     out_tdata,   // [63:0] next_row_cells
  output logic                                 out_tlast,   // frame_done
  input  wire logic                            cfg_wr_en,
  input  wire logic [cave_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cave_pkg::CFG_DAT_W-1:0]  cfg_wdata
);

  logic [cave_pkg::LIMIT_W-1:0] death_r;
  logic [cave_pkg::LIMIT_W-1:0] birth_r;
  logic [cave_pkg::WIDTH_W-1:0] width_r;

  logic [cave_pkg::CELL_W-1:0]  above_r;
  logic [cave_pkg::CELL_W-1:0]  above_nxt;
  logic [cave_pkg::CELL_W-1:0]  middle_r;
  logic [cave_pkg::CELL_W-1:0]  middle_nxt;
  logic                         mid_valid_r;
  logic                         mid_valid_nxt;

  logic [cave_pkg::CELL_W-1:0]  last_above;
  logic [cave_pkg::CELL_W-1:0]  res_mid;
  logic [cave_pkg::CELL_W-1:0]  res_last;
  logic                         in_acc;
  logic                         room;
  cave_pkg::cave_push_t         push;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      death_r <= cave_pkg::DEATH_RST;
      birth_r <= cave_pkg::BIRTH_RST;
      width_r <= cave_pkg::WIDTH_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        cave_pkg::CFG_DEATH_LIMIT: death_r <= cfg_wdata[cave_pkg::LIMIT_W-1:0];
        cave_pkg::CFG_BIRTH_LIMIT: birth_r <= cfg_wdata[cave_pkg::LIMIT_W-1:0];
        cave_pkg::CFG_ROW_WIDTH:   width_r <= cfg_wdata[cave_pkg::WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_tready = room;
  assign in_acc    = in_tvalid && in_tready;

  // Stored middle row with the incoming row below it.
  cave_row_gen u_gen_mid (
    .above       (above_r),
    .mid         (middle_r),
    .below       (in_tdata),
    .death_limit (death_r),
    .birth_limit (birth_r),
    .row_width   (width_r),
    .next_row    (res_mid)
  );

  // Final row, with the outside below it.
  assign last_above = mid_valid_r ? middle_r : above_r;

  cave_row_gen u_gen_last (
    .above       (last_above),
    .mid         (in_tdata),
    .below       ('1),
    .death_limit (death_r),
    .birth_limit (birth_r),
    .row_width   (width_r),
    .next_row    (res_last)
  );

  // Results of this transaction, oldest first.
  always_comb begin
    push.n        = '0;
    push.e0.cells = res_mid;
    push.e0.done  = 1'b0;
    push.e1.cells = res_last;
    push.e1.done  = 1'b1;
    if (in_acc) begin
      push.n = cave_pkg::PUSH_W'(mid_valid_r) + cave_pkg::PUSH_W'(in_tlast);
      if (!mid_valid_r) begin
        push.e0.cells = res_last;
        push.e0.done  = 1'b1;
      end
    end
  end

  // Row window shift; a final row returns the window to its start state.
  always_comb begin
    above_nxt     = above_r;
    middle_nxt    = middle_r;
    mid_valid_nxt = mid_valid_r;
    if (in_acc) begin
      if (in_tlast) begin
        above_nxt     = '1;
        middle_nxt    = '0;
        mid_valid_nxt = 1'b0;
      end else begin
        if (mid_valid_r) begin
          above_nxt = middle_r;
        end
        middle_nxt    = in_tdata;
        mid_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      above_r     <= '1;
      middle_r    <= '0;
      mid_valid_r <= 1'b0;
    end else begin
      above_r     <= above_nxt;
      middle_r    <= middle_nxt;
      mid_valid_r <= mid_valid_nxt;
    end
  end

  cave_out_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .room       (room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // Window state checks.
  `CAVE_ASSERT(a_final_clears, (in_acc && in_tlast) |=> (!mid_valid_r && above_r == '1), "final row did not clear window")
  `CAVE_ASSERT(a_row_kept, (in_acc && !in_tlast) |=> (mid_valid_r && middle_r == $past(in_tdata)), "row not stored")
  `CAVE_ASSERT(a_above_outside, !mid_valid_r |-> (above_r == '1), "row above not outside at map start")

endmodule

`default_nettype wire
